// ----- rtl/gfau_pkg.sv -----
// gfau_pkg: types, codes and field helpers shared by the gf(2^m) arithmetic unit
// used by gfau_mul, gfau_dpath, gfau_ctrl and gf2m_arithmetic_unit; no dependencies
package gfau_pkg;

  localparam int unsigned MAX_DEGREE = 15;
  localparam int unsigned ELEM_W     = MAX_DEGREE;
  localparam int unsigned DEG_W      = 4;
  localparam int unsigned POLY_W     = 16;
  localparam int unsigned EXP_W      = 31;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned RCNT_W     = 5;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_W      = 16;

  localparam logic [DEG_W-1:0]  DEGREE_RST = DEG_W'(8);
  localparam logic [POLY_W-1:0] POLY_RST   = POLY_W'(285);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_DEGREE = 1'b0,
    CFG_POLY   = 1'b1
  } gfau_cfg_e;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_DIV = 3'd2,
    OP_POW = 3'd3,
    OP_INV = 3'd4
  } gfau_op_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_DIV_ZERO = 2'd1,
    STAT_INV_ZERO = 2'd2,
    STAT_RANGE    = 2'd3
  } gfau_status_e;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MSEL_AB    = 2'd0,
    MSEL_SQ    = 2'd1,
    MSEL_BASE  = 2'd2,
    MSEL_FINAL = 2'd3
  } gfau_msel_e;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_WAIT,
    S_REDUCE,
    S_EXP_LOAD,
    S_SQ_GO,
    S_SQ_WAIT,
    S_PM_GO,
    S_PM_WAIT,
    S_FIN_GO,
    S_FIN_WAIT,
    S_FINISH
  } gfau_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       red_step;
    logic       exp_init;
    logic       exp_lim;
    logic       base_b;
    logic       mul_go;
    gfau_msel_e msel;
    logic       acc_wr;
    logic       idx_dec;
    logic       finish;
  } gfau_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    gfau_op_e op;
    logic     err;
    logic     a_zero;
    logic     red_last;
    logic     exp_bit;
    logic     idx_zero;
    logic     mul_done;
  } gfau_stat_t;

  // element mask 2^m - 1
  function automatic logic [ELEM_W-1:0] gfau_mask(input logic [DEG_W-1:0] m);
    logic [ELEM_W:0] t;
    t = ({{ELEM_W{1'b0}}, 1'b1} << m) - {{ELEM_W{1'b0}}, 1'b1};
    return t[ELEM_W-1:0];
  endfunction

  // multiply by x and reduce
  function automatic logic [ELEM_W-1:0] gfau_xtime(input logic [ELEM_W-1:0] x,
                                                   input logic [ELEM_W-1:0] mask,
                                                   input logic [ELEM_W-1:0] top,
                                                   input logic [ELEM_W-1:0] poly);
    logic             c;
    logic [ELEM_W-1:0] y;
    c = |(x & top);
    y = (x << 1) & mask;
    if (c) y = y ^ poly;
    return y;
  endfunction

  // one digit of msb-first shift-and-add multiplication
  function automatic logic [ELEM_W-1:0] gfau_digit(input logic [ELEM_W-1:0] r,
                                                   input logic [ELEM_W-1:0] x,
                                                   input logic [DIGIT_W-1:0] d,
                                                   input logic [ELEM_W-1:0] mask,
                                                   input logic [ELEM_W-1:0] poly);
    logic [ELEM_W-1:0] acc;
    logic [ELEM_W-1:0] top;
    acc = r;
    top = mask ^ (mask >> 1);
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      acc = gfau_xtime(acc, mask, top, poly);
      if (d[i]) acc = acc ^ x;
    end
    return acc;
  endfunction

endpackage

// ----- rtl/gfau_mul.sv -----
// gfau_mul: digit-serial gf(2^m) multiplier, eight multiplier bits a cycle
// depends on gfau_pkg
module gfau_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   x_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   y_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   mask_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   poly_i,
  output logic                          done_o,
  output logic [gfau_pkg::ELEM_W-1:0]   prod_o
);
  import gfau_pkg::*;

  localparam int unsigned HI_W = ELEM_W - DIGIT_W;

  logic                phase_q, phase_d;
  logic                done_q, done_d;
  logic [ELEM_W-1:0]   x_q;
  logic [DIGIT_W-1:0]  ylo_q;
  logic [ELEM_W-1:0]   r_q;
  logic [DIGIT_W-1:0]  yhi;

  assign yhi = {{(DIGIT_W-HI_W){1'b0}}, y_i[ELEM_W-1:DIGIT_W]};

  // phase and done control
  always_comb begin
    phase_d = start_i;
    done_d  = phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // high digit on start, low digit in the following cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      ylo_q <= y_i[DIGIT_W-1:0];
      r_q   <= gfau_digit('0, x_i, yhi, mask_i, poly_i);
    end else if (phase_q) begin
      r_q   <= gfau_digit(r_q, x_q, ylo_q, mask_i, poly_i);
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !phase_q)
    else $error("multiplier restarted while a product was in flight");
`endif

endmodule

// ----- rtl/gfau_dpath.sv -----
// gfau_dpath: configuration registers, operand and exponent registers, range checks,
// exponent reduction and the accumulator around the multiplier; depends on gfau_pkg, gfau_mul
module gfau_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [gfau_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [gfau_pkg::MODE_W-1:0]   mode_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   operand_a_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   operand_b_i,
  input  logic [gfau_pkg::EXP_W-1:0]    exponent_i,
  input  gfau_pkg::gfau_cmd_t           cmd_i,
  output gfau_pkg::gfau_stat_t          stat_o,
  output logic                          done_o,
  output logic [gfau_pkg::ELEM_W-1:0]   result_o,
  output logic [gfau_pkg::STAT_W-1:0]   status_o
);
  import gfau_pkg::*;

  logic [DEG_W-1:0]   degree_q;
  logic [POLY_W-1:0]  poly_q;
  logic [DEG_W-1:0]   m_eff;
  logic [ELEM_W-1:0]  mask_eff;

  logic [DEG_W-1:0]   m_q;
  logic [ELEM_W-1:0]  mask_q;
  logic [ELEM_W-1:0]  plow_q;
  logic [MODE_W-1:0]  mode_q;
  logic [ELEM_W-1:0]  a_q, b_q;
  logic [EXP_W-1:0]   e_q;
  logic [ELEM_W-1:0]  rem_q;
  logic [RCNT_W-1:0]  rcnt_q;
  logic [ELEM_W-1:0]  exp_q;
  logic [ELEM_W-1:0]  base_q;
  logic [ELEM_W-1:0]  acc_q;
  logic [IDX_W-1:0]   idx_q;

  logic               done_q;
  logic [ELEM_W-1:0]  result_q, result_d;
  gfau_status_e       status_q, status_d;

  logic [ELEM_W:0]    red_t;
  logic [ELEM_W:0]    red_d;
  logic               a_oor, b_oor, range_err;
  gfau_op_e           op;
  logic [ELEM_W-1:0]  mx, my;
  logic               mul_done;
  logic [ELEM_W-1:0]  prod;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RST;
      poly_q   <= POLY_RST;
    end else if (cfg_we_i) begin
      unique case (gfau_cfg_e'(cfg_addr_i))
        CFG_DEGREE: degree_q <= cfg_wdata_i[DEG_W-1:0];
        CFG_POLY:   poly_q   <= cfg_wdata_i[POLY_W-1:0];
        default:    ;
      endcase
    end
  end

  // effective degree, zero acts as one
  assign m_eff    = (degree_q == '0) ? DEG_W'(1) : degree_q;
  assign mask_eff = gfau_mask(m_eff);

  // range and fault decode
  assign op    = gfau_op_e'(mode_q);
  assign a_oor = |(a_q & ~mask_q);
  assign b_oor = |(b_q & ~mask_q);

  always_comb begin
    case (op) inside
      OP_ADD, OP_MUL, OP_DIV: range_err = a_oor | b_oor;
      OP_POW, OP_INV:         range_err = a_oor;
      default:                range_err = 1'b1;
    endcase
    if (range_err) begin
      status_d = STAT_RANGE;
    end else if (op == OP_DIV && b_q == '0) begin
      status_d = STAT_DIV_ZERO;
    end else if (op == OP_INV && a_q == '0) begin
      status_d = STAT_INV_ZERO;
    end else begin
      status_d = STAT_OK;
    end
  end

  // result selection
  always_comb begin
    if (status_d != STAT_OK) begin
      result_d = '0;
    end else if (op == OP_ADD) begin
      result_d = a_q ^ b_q;
    end else if (op == OP_POW && a_q == '0) begin
      result_d = '0;
    end else begin
      result_d = acc_q;
    end
  end

  // exponent reduction modulo 2^m - 1, one exponent bit a cycle
  assign red_t = {rem_q, e_q[EXP_W-1]};
  assign red_d = (red_t >= {1'b0, mask_q}) ? (red_t - {1'b0, mask_q}) : red_t;

  // multiplier operand selection
  always_comb begin
    unique case (cmd_i.msel)
      MSEL_AB:    begin mx = a_q;   my = b_q;    end
      MSEL_SQ:    begin mx = acc_q; my = acc_q;  end
      MSEL_BASE:  begin mx = acc_q; my = base_q; end
      MSEL_FINAL: begin mx = a_q;   my = acc_q;  end
      default:    begin mx = a_q;   my = b_q;    end
    endcase
  end

  gfau_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_go),
    .x_i     (mx),
    .y_i     (my),
    .mask_i  (mask_q),
    .poly_i  (plow_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // operand, exponent and accumulator registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q    <= m_eff;
      mask_q <= mask_eff;
      plow_q <= poly_q[ELEM_W-1:0] & mask_eff;
      mode_q <= mode_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      e_q    <= exponent_i;
      rem_q  <= '0;
      rcnt_q <= '0;
    end else if (cmd_i.red_step) begin
      rem_q  <= red_d[ELEM_W-1:0];
      e_q    <= e_q << 1;
      rcnt_q <= rcnt_q + RCNT_W'(1);
    end
    if (cmd_i.exp_init) begin
      exp_q  <= cmd_i.exp_lim ? (mask_q - ELEM_W'(1)) : rem_q;
      base_q <= cmd_i.base_b ? b_q : a_q;
      acc_q  <= ELEM_W'(1);
      idx_q  <= m_q - DEG_W'(1);
    end else begin
      if (cmd_i.acc_wr) acc_q <= prod;
      if (cmd_i.idx_dec) idx_q <= idx_q - IDX_W'(1);
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  // result strobe and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) status_q <= status_d;
    end
  end

  // status toward the controller
  always_comb begin
    stat_o.op       = op;
    stat_o.err      = (status_d != STAT_OK);
    stat_o.a_zero   = (a_q == '0);
    stat_o.red_last = (rcnt_q == RCNT_W'(EXP_W - 1));
    stat_o.exp_bit  = exp_q[idx_q];
    stat_o.idx_zero = (idx_q == '0);
    stat_o.mul_done = mul_done;
  end

  assign done_o   = done_q;
  assign result_o = result_q;
  assign status_o = status_q;

`ifndef ASSERT_OFF
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STAT_OK) |-> (result_q == '0))
    else $error("faulted word carries a nonzero result");
  a_acc_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_wr |-> ((prod & ~mask_q) == '0))
    else $error("product outside the field");
`endif

endmodule

// ----- rtl/gfau_ctrl.sv -----
// gfau_ctrl: sequencer for decode, exponent reduction and square-and-multiply
// depends on gfau_pkg
module gfau_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  gfau_pkg::gfau_stat_t  stat_i,
  output gfau_pkg::gfau_cmd_t   cmd_o
);
  import gfau_pkg::*;

  gfau_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.msel = MSEL_AB;
    busy    = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.err || stat_i.op == OP_ADD ||
            (stat_i.op == OP_POW && stat_i.a_zero)) begin
          state_d = S_FINISH;
        end else begin
          unique case (stat_i.op)
            OP_MUL: begin
              cmd_o.mul_go = 1'b1;
              cmd_o.msel   = MSEL_AB;
              state_d      = S_MUL_WAIT;
            end
            OP_POW: state_d = S_REDUCE;
            OP_INV: begin
              cmd_o.exp_init = 1'b1;
              cmd_o.exp_lim  = 1'b1;
              state_d        = S_SQ_GO;
            end
            OP_DIV: begin
              cmd_o.exp_init = 1'b1;
              cmd_o.exp_lim  = 1'b1;
              cmd_o.base_b   = 1'b1;
              state_d        = S_SQ_GO;
            end
            default: state_d = S_FINISH;
          endcase
        end
      end
      S_MUL_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_wr = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (stat_i.red_last) state_d = S_EXP_LOAD;
      end
      S_EXP_LOAD: begin
        cmd_o.exp_init = 1'b1;
        state_d        = S_SQ_GO;
      end
      S_SQ_GO: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel   = MSEL_SQ;
        state_d      = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_wr = 1'b1;
          if (stat_i.exp_bit) begin
            state_d = S_PM_GO;
          end else if (stat_i.idx_zero) begin
            state_d = (stat_i.op == OP_DIV) ? S_FIN_GO : S_FINISH;
          end else begin
            cmd_o.idx_dec = 1'b1;
            state_d       = S_SQ_GO;
          end
        end
      end
      S_PM_GO: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel   = MSEL_BASE;
        state_d      = S_PM_WAIT;
      end
      S_PM_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_wr = 1'b1;
          if (stat_i.idx_zero) begin
            state_d = (stat_i.op == OP_DIV) ? S_FIN_GO : S_FINISH;
          end else begin
            cmd_o.idx_dec = 1'b1;
            state_d       = S_SQ_GO;
          end
        end
      end
      S_FIN_GO: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.msel   = MSEL_FINAL;
        state_d      = S_FIN_WAIT;
      end
      S_FIN_WAIT: begin
        if (stat_i.mul_done) begin
          cmd_o.acc_wr = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_acc_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_wr |-> stat_i.mul_done)
    else $error("accumulator written without a finished product");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mul_done |-> (state_q == S_MUL_WAIT || state_q == S_SQ_WAIT ||
                         state_q == S_PM_WAIT || state_q == S_FIN_WAIT))
    else $error("product finished outside a wait state");
  a_reduce_pow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.red_step |-> (stat_i.op == OP_POW))
    else $error("exponent reduction outside a power operation");
`endif

endmodule

// ----- rtl/gf2m_arithmetic_unit.sv -----
// gf2m_arithmetic_unit: add, multiply, divide, power and inverse over gf(2^m), m 1..15
// add, faults and zero-base power finish after decode; multiply is one multiplier product,
// inverse is square-and-multiply to a^(2^m-2), divide is a * inv(b), power first reduces
// the exponent bit-serially modulo 2^m - 1. one word at a time, next start taken in the
// cycle done_o is high; the receiver cannot stall. async active-low reset returns to idle
// with degree 8 and polynomial 285. depends on gfau_pkg, gfau_ctrl, gfau_dpath
module gf2m_arithmetic_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [gfau_pkg::MODE_W-1:0]   mode_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   operand_a_i,
  input  logic [gfau_pkg::ELEM_W-1:0]   operand_b_i,
  input  logic [gfau_pkg::EXP_W-1:0]    exponent_i,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [gfau_pkg::CFG_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [gfau_pkg::ELEM_W-1:0]   result_o,
  output logic [gfau_pkg::STAT_W-1:0]   status_o
);
  import gfau_pkg::*;

  gfau_cmd_t  cmd;
  gfau_stat_t stat;

  // sequencer
  gfau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath
  gfau_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .exponent_i  (exponent_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .result_o    (result_o),
    .status_o    (status_o)
  );

endmodule
